[src/i2cm_pkg.sv]
`timescale 1ns / 1ps

package i2cm_pkg;

  // Tick counter width
  localparam int TICK_WIDTH = 16;
  // Width of the delay register
  localparam int DELAY_W = 16;
  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(100);

  // Command / operation codes
  localparam logic [1:0] OP_IDLE  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  // Phase bookkeeping
  localparam int PH_W = 5;
  localparam logic [PH_W-1:0] END_START = PH_W'(2);
  localparam logic [PH_W-1:0] END_STOP  = PH_W'(3);
  localparam logic [PH_W-1:0] END_WRITE = PH_W'(18);
  localparam logic [PH_W-1:0] PH_ACK_LOW  = PH_W'(16);
  localparam logic [PH_W-1:0] PH_ACK_HIGH = PH_W'(17);

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One classified input word
  typedef struct packed {
    logic       is_cmd;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       sda_in;
  } word_t;

  // Queue status towards the back end
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

  localparam logic [32:0] TICK_MAX = (33'd1 << TICK_WIDTH) - 33'd1;

  // Delay limit: zero acts as one, saturate to what the counter can hold
  function automatic logic [TICK_WIDTH-1:0] delay_limit(input logic [DELAY_W-1:0] delay);
    logic [32:0] d;
    d = 33'(delay);
    if (d == 33'd0) d = 33'd1;
    if (d > TICK_MAX) d = TICK_MAX;
    return d[TICK_WIDTH-1:0];
  endfunction

endpackage

[src/i2cm_front.sv]
`timescale 1ns / 1ps

module i2cm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_data_byte,
  input  logic               in_sda_in,
  input  logic               q_full,
  output logic               push,
  output i2cm_pkg::word_t    push_word
);
  import i2cm_pkg::*;

  logic  valid_r, valid_nxt;
  word_t word_r;
  logic  accept;

  // Hold a word only while the queue is full
  assign push     = valid_r && !q_full;
  assign in_stall = valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push_word = word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) valid_nxt = 1'b1;
    else if (push) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture and classify the incoming word
  always_ff @(posedge clk) begin
    if (accept) begin
      word_r.is_cmd    <= (in_command != OP_IDLE);
      word_r.command   <= in_command;
      word_r.data_byte <= in_data_byte;
      word_r.sda_in    <= in_sda_in;
    end
  end

endmodule

[src/i2cm_queue.sv]
`timescale 1ns / 1ps

module i2cm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  i2cm_pkg::word_t    push_word,
  input  logic               pop,
  output i2cm_pkg::word_t    pop_word,
  output i2cm_pkg::q_stat_t  stat
);
  import i2cm_pkg::*;

  word_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign stat.not_empty = (count_r != '0);
  assign stat.full      = (count_r == QCNT_W'(QDEPTH));
  assign pop_word       = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_word;
  end

endmodule

[src/i2cm_engine.sv]
`timescale 1ns / 1ps

module i2cm_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic [i2cm_pkg::DELAY_W-1:0] cfg_data,
  input  i2cm_pkg::q_stat_t           stat,
  input  i2cm_pkg::word_t             pop_word,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_scl_out,
  output logic                        out_sda_out,
  output logic                        out_busy_res,
  output logic                        out_done_res,
  output logic                        out_ack_seen
);
  import i2cm_pkg::*;

  logic [DELAY_W-1:0]    delay_r;
  logic [TICK_WIDTH-1:0] tick_r, tick_nxt;
  logic [PH_W-1:0]       ph_r, ph_nxt;
  logic [1:0]            op_r, op_nxt;
  logic [7:0]            sh_r, sh_nxt;
  logic                  scl_r, scl_nxt;
  logic                  sda_r, sda_nxt;
  logic                  ack_r, ack_nxt;
  logic                  done_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  busy_o_r, done_o_r;

  logic                  enter;
  logic [TICK_WIDTH-1:0] tick_inc;

  // Step when a word is queued and the output register is free
  assign pop = stat.not_empty && (!out_valid_r || !out_stall);
  assign tick_inc = tick_r + 1'b1;

  // One bus tick
  always_comb begin
    tick_nxt = tick_r;
    ph_nxt   = ph_r;
    op_nxt   = op_r;
    sh_nxt   = sh_r;
    scl_nxt  = scl_r;
    sda_nxt  = sda_r;
    ack_nxt  = ack_r;
    done_nxt = 1'b0;
    enter    = 1'b0;

    if (op_r == OP_IDLE) begin
      if (pop_word.is_cmd) begin
        op_nxt   = pop_word.command;
        ph_nxt   = '0;
        tick_nxt = '0;
        sh_nxt   = pop_word.data_byte;
        enter    = 1'b1;
      end
    end else begin
      tick_nxt = tick_inc;
      if (tick_inc >= delay_limit(delay_r)) begin
        tick_nxt = '0;
        ph_nxt   = ph_r + 1'b1;
        enter    = 1'b1;
      end
    end

    // Level changes on entry to a phase
    if (enter) begin
      case (op_nxt)
        OP_START: begin
          if (ph_nxt == '0) begin
            sda_nxt = 1'b1;
            scl_nxt = 1'b1;
          end else if (ph_nxt == PH_W'(1)) begin
            sda_nxt = 1'b0;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        OP_STOP: begin
          if (ph_nxt == '0) sda_nxt = 1'b0;
          else if (ph_nxt == PH_W'(1)) scl_nxt = 1'b1;
          else if (ph_nxt == PH_W'(2)) sda_nxt = 1'b1;
        end
        OP_WRITE: begin
          if (ph_nxt < PH_ACK_LOW) begin
            if (!ph_nxt[0]) begin
              if (ph_nxt != '0) scl_nxt = 1'b0;
              sda_nxt = sh_nxt[7];
              sh_nxt  = {sh_nxt[6:0], 1'b0};
            end else begin
              scl_nxt = 1'b1;
            end
          end else if (ph_nxt == PH_ACK_LOW) begin
            scl_nxt = 1'b0;
            sda_nxt = 1'b1;
          end else if (ph_nxt == PH_ACK_HIGH) begin
            scl_nxt = 1'b1;
          end else begin
            ack_nxt = !pop_word.sda_in;
            scl_nxt = 1'b0;
          end
        end
        default: ;
      endcase

      // End of sequence
      if (op_r != OP_IDLE) begin
        if ((op_r == OP_START && ph_nxt >= END_START) ||
            (op_r == OP_STOP  && ph_nxt >= END_STOP)  ||
            (op_r == OP_WRITE && ph_nxt >= END_WRITE)) begin
          op_nxt   = OP_IDLE;
          ph_nxt   = '0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  // Engine state, delay register and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r     <= DELAY_RESET;
      tick_r      <= '0;
      ph_r        <= '0;
      op_r        <= OP_IDLE;
      sh_r        <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ack_r       <= 1'b0;
      out_valid_r <= 1'b0;
      busy_o_r    <= 1'b0;
      done_o_r    <= 1'b0;
    end else begin
      if (cfg_valid) delay_r <= cfg_data;
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        tick_r   <= tick_nxt;
        ph_r     <= ph_nxt;
        op_r     <= op_nxt;
        sh_r     <= sh_nxt;
        scl_r    <= scl_nxt;
        sda_r    <= sda_nxt;
        ack_r    <= ack_nxt;
        busy_o_r <= (op_nxt != OP_IDLE);
        done_o_r <= done_nxt;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_scl_out  = scl_r;
  assign out_sda_out  = sda_r;
  assign out_busy_res = busy_o_r;
  assign out_done_res = done_o_r;
  assign out_ack_seen = ack_r;

endmodule

[src/i2c_master_bit_engine.sv]
`timescale 1ns / 1ps
// I2C master bit engine.
// Input channel (in_valid / in_stall): one word per bus tick, carrying a
// command (none, start, stop, write byte), the byte to write and the sampled
// SDA level. A command that arrives while a sequence runs is ignored.
// Result channel (out_valid / out_stall): exactly one word per input word,
// in order: SCL and SDA drive levels, busy, a one-word done pulse and the
// ACK result of the last write.
// Configuration channel (cfg_valid / cfg_ready): writes delay_ticks, the
// ticks per half-bit delay; cfg_ready is always high. Write only when idle.
// An accepted input word passes the front capture register, a queue entry
// and the engine output register before its result word is valid.
// Throughput is one word per cycle while the receiver does not stall.
// When the receiver stalls, the output register
// keeps its word, the queue takes four more and the front register one more;
// then in_stall rises.
// Reset (rst_n low, synchronous) empties the queue, returns the engine to
// idle with SCL and SDA released, clears ACK and loads delay_ticks with 100.
module i2c_master_bit_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_data_byte,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_ack_seen,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import i2cm_pkg::*;

  word_t   push_word, pop_word;
  q_stat_t stat;
  logic    push, pop;

  assign cfg_ready = 1'b1;

  i2cm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_data_byte (in_data_byte),
    .in_sda_in    (in_sda_in),
    .q_full       (stat.full),
    .push         (push),
    .push_word    (push_word)
  );

  i2cm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .stat      (stat)
  );

  i2cm_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .stat         (stat),
    .pop_word     (pop_word),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_scl_out  (out_scl_out),
    .out_sda_out  (out_sda_out),
    .out_busy_res (out_busy_res),
    .out_done_res (out_done_res),
    .out_ack_seen (out_ack_seen)
  );

endmodule
